// ===== rtl/kmpf_pkg.sv =====
// ---------------------------------------------------------------------------
// kmpf_pkg: shared types and constants of the first-match finder
// Holds the configuration register codes, the state type of the control
// sequencer and the control bundle that drives the matching chain.
// ---------------------------------------------------------------------------
package kmpf_pkg;

    // Pattern storage is fixed by the two 64-bit pattern registers.
    localparam int unsigned PAT_BYTES = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 5;
    localparam int unsigned INDEX_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        ST_RUN,
        ST_REPLAY
    } state_t;

    // Shift a byte into the chain, or clear every cell.
    typedef struct packed {
        logic              shift;
        logic              clear;
        logic [BYTE_W-1:0] data;
    } chain_ctrl_t;

endpackage

// ===== rtl/kmpf_cell.sv =====
// ---------------------------------------------------------------------------
// kmpf_cell: one position of the matching chain
// Holds one bit: the pattern prefix ending at this cell is a suffix of the
// text seen so far. It extends its left neighbour's bit by one byte.
// ---------------------------------------------------------------------------
module kmpf_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  kmpf_pkg::chain_ctrl_t               ctrl,
    input  logic                                flush,
    input  logic                                prev_match,
    input  logic                                in_use,
    input  logic [kmpf_pkg::BYTE_W-1:0]         pat_byte,
    output logic                                extend,
    output logic                                match
);

    logic match_reg;
    logic match_next;

    assign extend = prev_match & in_use & (pat_byte == ctrl.data);

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.clear | flush)
        begin
            match_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            match_next = extend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign match = match_reg;

endmodule

// ===== rtl/kmpf_chain.sv =====
// ---------------------------------------------------------------------------
// kmpf_chain: row of matching cells
// Cell k tracks whether pattern bytes 0..k end the text. Reports a full
// match on the shifted byte and the longest prefix currently held.
// ---------------------------------------------------------------------------
module kmpf_chain #(
    parameter int unsigned NCELL = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  kmpf_pkg::chain_ctrl_t                       ctrl,
    input  logic [kmpf_pkg::LEN_W-1:0]                  pat_len,
    input  logic [NCELL-1:0][kmpf_pkg::BYTE_W-1:0]      pat_bytes,
    output logic                                        hit,
    output logic [kmpf_pkg::LEN_W-1:0]                  prefix_len
);

    logic                  flush;
    logic [NCELL-1:0]      extend;
    logic [NCELL-1:0]      match;

    // A completed match empties the chain, as the search then starts over.
    assign flush = ctrl.shift & hit;

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        logic prev;
        if (k == 0)
        begin : g_first
            assign prev = 1'b1;
        end
        else
        begin : g_rest
            assign prev = match[k-1];
        end

        kmpf_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .flush      (flush),
            .prev_match (prev),
            .in_use     (kmpf_pkg::LEN_W'(k) < pat_len),
            .pat_byte   (pat_bytes[k]),
            .extend     (extend[k]),
            .match      (match[k])
        );
    end

    always_comb
    begin
        hit        = 1'b0;
        prefix_len = '0;
        for (int unsigned k = 0; k < NCELL; k++)
        begin
            if (kmpf_pkg::LEN_W'(k + 1) == pat_len)
            begin
                hit = extend[k];
            end
            if (match[k])
            begin
                prefix_len = kmpf_pkg::LEN_W'(k + 1);
            end
        end
    end

endmodule

// ===== rtl/kmp_first_match_finder.sv =====
// ---------------------------------------------------------------------------
// kmp_first_match_finder: first occurrence of a byte pattern in a text stream
// Streams text bytes through a chain of compare cells and reports the start
// index of the first match, or a not-found result at the last byte.
// ---------------------------------------------------------------------------
// The block takes one text byte per clock cycle and gives one result per
// text: at the byte that completes the first match (found set, with the
// match's start index), or at the byte marked last when no match was seen.
// Matching is done by a row of cells, one per pattern byte; cell k holds
// whether pattern bytes 0 to k are the most recent text bytes, so every
// partial match is tracked at once and no failure-table walk is needed.
// A result waits in an output register; the next byte is taken while it
// waits as long as the register is free or being emptied in the same cycle.
// Any write to a pattern register rebuilds the cell contents so that the
// search continues from the prefix length matched so far: the chain is
// cleared and then fed the first q pattern bytes, one per cycle, where q is
// that prefix length (zero if it is not below the new length). While the
// replay runs no text byte is taken; configuration writes are still
// accepted and restart the rebuild. An empty pattern matches at index
// zero on the first byte. Once the text runs past MAX_TEXT bytes the
// position saturates and too_long is set in the result.
// ---------------------------------------------------------------------------
module kmp_first_match_finder #(
    parameter int unsigned MAX_PATTERN = 16,
    parameter int unsigned MAX_TEXT    = 65536
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // configuration write channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [kmpf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [kmpf_pkg::CFG_DAT_W-1:0]          cfg_data,
    // text input channel
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [kmpf_pkg::BYTE_W-1:0]             text_byte,
    input  logic                                    last_byte,
    // result channel
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    found,
    output logic [kmpf_pkg::INDEX_W-1:0]            match_index,
    output logic                                    too_long
);

    // The cell count follows the pattern limit, bounded by register storage.
    localparam int unsigned NCELL =
        (MAX_PATTERN < kmpf_pkg::PAT_BYTES) ? MAX_PATTERN : kmpf_pkg::PAT_BYTES;
    localparam int unsigned POS_W = $clog2(MAX_TEXT) + 1;
    localparam int unsigned SUM_W = (POS_W + 1 > kmpf_pkg::INDEX_W + 1) ?
                                    POS_W + 1 : kmpf_pkg::INDEX_W + 1;
    localparam int unsigned REP_W = $clog2(kmpf_pkg::PAT_BYTES);

    // Configuration registers
    logic [kmpf_pkg::PAT_BYTES-1:0][kmpf_pkg::BYTE_W-1:0] pat_bytes;
    logic [kmpf_pkg::CFG_DAT_W-1:0] pattern_low_reg;
    logic [kmpf_pkg::CFG_DAT_W-1:0] pattern_high_reg;
    logic [kmpf_pkg::LEN_W-1:0]     pattern_length_reg;
    logic                           cfg_write;
    logic                           cfg_hit;
    logic [kmpf_pkg::LEN_W-1:0]     eff_len;

    // Sequencer and search state
    kmpf_pkg::state_t               state_reg;
    kmpf_pkg::state_t               state_next;
    logic [REP_W-1:0]               rep_cnt_reg;
    logic [REP_W-1:0]               rep_cnt_next;
    logic [kmpf_pkg::LEN_W-1:0]     q_reg;
    logic [kmpf_pkg::LEN_W-1:0]     q_eff;
    logic                           chain_live_reg;
    logic [POS_W-1:0]               pos_reg;
    logic                           reported_reg;
    kmpf_pkg::chain_ctrl_t          ctrl;
    logic                           chain_hit;
    logic [kmpf_pkg::LEN_W-1:0]     prefix_len;

    // Result datapath
    logic                           accept;
    logic                           at_limit;
    logic                           hit_now;
    logic                           emit;
    logic [SUM_W-1:0]               pos_inc;
    logic [SUM_W-1:0]               len_ext;
    logic [SUM_W-1:0]               start_full;
    logic [kmpf_pkg::INDEX_W-1:0]   start_idx;
    logic                           out_valid_reg;
    logic                           found_reg;
    logic [kmpf_pkg::INDEX_W-1:0]   match_index_reg;
    logic                           too_long_reg;

    // ------------------------------------------------------------------
    // Configuration port. Writes are always taken; a write to an index
    // beyond the register list changes nothing.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_comb
    begin
        unique case (kmpf_pkg::cfg_reg_t'(cfg_index))
            kmpf_pkg::REG_PATTERN_LOW,
            kmpf_pkg::REG_PATTERN_HIGH,
            kmpf_pkg::REG_PATTERN_LENGTH: cfg_hit = cfg_write;
            default:                      cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (kmpf_pkg::cfg_reg_t'(cfg_index))
                kmpf_pkg::REG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                kmpf_pkg::REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                kmpf_pkg::REG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[kmpf_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign pat_bytes = {pattern_high_reg, pattern_low_reg};

    // Lengths above the cell count are treated as the cell count.
    assign eff_len = (pattern_length_reg > kmpf_pkg::LEN_W'(NCELL)) ?
                     kmpf_pkg::LEN_W'(NCELL) : pattern_length_reg;

    // A held prefix that is not shorter than the pattern restarts empty.
    assign q_eff = (q_reg >= eff_len) ? '0 : q_reg;

    // ------------------------------------------------------------------
    // Handshake and match decision
    // ------------------------------------------------------------------
    assign in_ready = (state_reg == kmpf_pkg::ST_RUN) & (~out_valid_reg | out_ready);
    assign accept   = in_valid & in_ready;

    assign at_limit = (pos_reg == POS_W'(MAX_TEXT));
    assign hit_now  = ~reported_reg & ((eff_len == '0) | chain_hit);
    assign emit     = accept & ~reported_reg & (hit_now | last_byte);

    // Start index is position + 1 - length, floored at zero and capped at
    // the width of the index field.
    assign pos_inc    = SUM_W'(pos_reg) + SUM_W'(1);
    assign len_ext    = SUM_W'(eff_len);
    assign start_full = (pos_inc >= len_ext) ? (pos_inc - len_ext) : '0;

    always_comb
    begin
        if (eff_len == '0)
        begin
            start_idx = '0;
        end
        else if (start_full > SUM_W'({kmpf_pkg::INDEX_W{1'b1}}))
        begin
            start_idx = {kmpf_pkg::INDEX_W{1'b1}};
        end
        else
        begin
            start_idx = start_full[kmpf_pkg::INDEX_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: runs text bytes through the chain, or replays the held
    // pattern prefix into it after a configuration write.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        rep_cnt_next = rep_cnt_reg;
        ctrl         = '0;

        unique case (state_reg)
            kmpf_pkg::ST_RUN:
            begin
                if (accept)
                begin
                    ctrl.shift = ~reported_reg;
                    ctrl.clear = last_byte;
                    ctrl.data  = text_byte;
                end
            end
            kmpf_pkg::ST_REPLAY:
            begin
                if (kmpf_pkg::LEN_W'(rep_cnt_reg) == q_eff)
                begin
                    state_next = kmpf_pkg::ST_RUN;
                end
                else
                begin
                    ctrl.shift   = 1'b1;
                    ctrl.data    = pat_bytes[rep_cnt_reg];
                    rep_cnt_next = rep_cnt_reg + REP_W'(1);
                end
            end
            default:
            begin
                state_next = kmpf_pkg::ST_RUN;
            end
        endcase

        // A pattern write empties the chain and starts the replay afresh.
        if (cfg_hit)
        begin
            state_next   = kmpf_pkg::ST_REPLAY;
            rep_cnt_next = '0;
            ctrl.shift   = 1'b0;
            ctrl.clear   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kmpf_pkg::ST_RUN;
            rep_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rep_cnt_reg <= rep_cnt_next;
        end
    end

    // The cells stand for the matched prefix only once a text byte has gone
    // through them since the last pattern write. Until then a replay may be
    // partial, or may have started empty because the held prefix was too
    // long for the new pattern, and the earlier figure still stands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_live_reg <= 1'b1;
        end
        else if (cfg_hit)
        begin
            chain_live_reg <= 1'b0;
        end
        else if (accept)
        begin
            chain_live_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (cfg_hit && chain_live_reg)
        begin
            q_reg <= prefix_len;
        end
    end

    // ------------------------------------------------------------------
    // Text position and report flag
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            reported_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                pos_reg      <= '0;
                reported_reg <= 1'b0;
            end
            else
            begin
                if (!at_limit)
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
                if (hit_now)
                begin
                    reported_reg <= 1'b1;
                end
            end
        end
    end

    kmpf_chain #(
        .NCELL (NCELL)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .pat_len    (eff_len),
        .pat_bytes  (pat_bytes[NCELL-1:0]),
        .hit        (chain_hit),
        .prefix_len (prefix_len)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            found_reg       <= hit_now;
            match_index_reg <= hit_now ? start_idx : '0;
            too_long_reg    <= at_limit;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign match_index = match_index_reg;
    assign too_long    = too_long_reg;

endmodule
